@@ hdl/trpc_pkg.sv @@
// ----------------------------------------------------------------------------
// trpc_pkg
// shared types, codes and the fixed system color table for the row colorizer
// ----------------------------------------------------------------------------
package trpc_pkg;

   localparam int PAL_DEPTH = 32;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int COLOR_W   = 6;

   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_BACKGROUND = 2'd1;
   localparam logic [1:0] OP_SPRITE     = 2'd2;

   localparam logic [2:0] LAST_COLUMN = 3'd7;

   typedef struct packed {
      logic              valid;
      logic [PAL_AW-1:0] addr;
      logic              opaque;
      logic [2:0]        column;
   } pix_req_type;

   typedef struct packed {
      logic busy;
      logic last_issue;
   } seq_status_type;

   function automatic logic [23:0] sys_rgb(input logic [COLOR_W-1:0] idx);
      logic [23:0] c;
      case (idx)
         6'd0:  c = 24'h808080;  6'd1:  c = 24'h003DA6;
         6'd2:  c = 24'h0012B0;  6'd3:  c = 24'h440096;
         6'd4:  c = 24'hA1005E;  6'd5:  c = 24'hC70028;
         6'd6:  c = 24'hBA0600;  6'd7:  c = 24'h8C1700;
         6'd8:  c = 24'h5C2F00;  6'd9:  c = 24'h104500;
         6'd10: c = 24'h054A00;  6'd11: c = 24'h00472E;
         6'd12: c = 24'h004166;  6'd13: c = 24'h000000;
         6'd14: c = 24'h050505;  6'd15: c = 24'h050505;
         6'd16: c = 24'hC7C7C7;  6'd17: c = 24'h0077FF;
         6'd18: c = 24'h2155FF;  6'd19: c = 24'h8237FA;
         6'd20: c = 24'hEB2FB5;  6'd21: c = 24'hFF2950;
         6'd22: c = 24'hFF2200;  6'd23: c = 24'hD63200;
         6'd24: c = 24'hC46200;  6'd25: c = 24'h358000;
         6'd26: c = 24'h058F00;  6'd27: c = 24'h008A55;
         6'd28: c = 24'h0099CC;  6'd29: c = 24'h212121;
         6'd30: c = 24'h090909;  6'd31: c = 24'h090909;
         6'd32: c = 24'hFFFFFF;  6'd33: c = 24'h0FD7FF;
         6'd34: c = 24'h69A2FF;  6'd35: c = 24'hD480FF;
         6'd36: c = 24'hFF45F3;  6'd37: c = 24'hFF618B;
         6'd38: c = 24'hFF8833;  6'd39: c = 24'hFF9C12;
         6'd40: c = 24'hFABC20;  6'd41: c = 24'h9FE30E;
         6'd42: c = 24'h2BF035;  6'd43: c = 24'h0CF0A4;
         6'd44: c = 24'h05FBFF;  6'd45: c = 24'h5E5E5E;
         6'd46: c = 24'h0D0D0D;  6'd47: c = 24'h0D0D0D;
         6'd48: c = 24'hFFFFFF;  6'd49: c = 24'hA6FCFF;
         6'd50: c = 24'hB3ECFF;  6'd51: c = 24'hDAABEB;
         6'd52: c = 24'hFFA8F9;  6'd53: c = 24'hFFABB3;
         6'd54: c = 24'hFFD2B0;  6'd55: c = 24'hFFEFA6;
         6'd56: c = 24'hFFF79C;  6'd57: c = 24'hD7E895;
         6'd58: c = 24'hA6EDAF;  6'd59: c = 24'hA2F2DA;
         6'd60: c = 24'h99FFFC;  6'd61: c = 24'hDDDDDD;
         6'd62: c = 24'h111111;  6'd63: c = 24'h111111;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/trpc_ram.sv @@
// ----------------------------------------------------------------------------
// trpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module trpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/trpc_pal_store.sv @@
// ----------------------------------------------------------------------------
// trpc_pal_store
// palette ram with per-entry written flags; unwritten entries read as zero
// ----------------------------------------------------------------------------
module trpc_pal_store
   import trpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [PAL_AW-1:0]  wr_addr,
   input  logic [COLOR_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [PAL_AW-1:0]  rd_addr,
   output logic [COLOR_W-1:0] color
);

   logic [PAL_DEPTH-1:0] written_ff;
   logic [PAL_DEPTH-1:0] written_in;
   logic                 hit_ff;
   logic                 hit_in;
   logic [COLOR_W-1:0]   rd_data;

   trpc_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(PAL_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
      hit_in = rd_en ? written_ff[rd_addr] : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         hit_ff     <= 1'b0;
      end else begin
         written_ff <= written_in;
         hit_ff     <= hit_in;
      end
   end

   assign color = hit_ff ? rd_data : '0;

endmodule

@@ hdl/trpc_row_seq.sv @@
// ----------------------------------------------------------------------------
// trpc_row_seq
// holds one row request and issues one palette read per pixel, left to right
// ----------------------------------------------------------------------------
module trpc_row_seq
   import trpc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [1:0]     req_operation,
   input  logic [7:0]     req_plane_low,
   input  logic [7:0]     req_plane_high,
   input  logic [4:0]     req_tile_column,
   input  logic [4:0]     req_tile_row_number,
   input  logic [7:0]     req_attribute_byte,
   input  logic [1:0]     req_sprite_palette,
   input  logic           req_flip_horizontal,
   input  logic           adv,
   output pix_req_type    issue,
   output seq_status_type status
);

   logic       busy_ff, busy_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] lo_ff, hi_ff;
   logic       sprite_ff, flip_ff;
   logic [1:0] group_ff, group_in;
   logic [1:0] quad;
   logic       accept, load, last_issue;
   logic [2:0] bidx;
   logic [1:0] pix;

   assign last_issue = busy_ff && (cnt_ff == LAST_COLUMN) && adv;
   assign req_stall  = busy_ff && !last_issue;
   assign accept     = req_valid && !req_stall;
   assign load       = accept && ((req_operation == OP_BACKGROUND) ||
                                  (req_operation == OP_SPRITE));

   always_comb begin
      quad     = {req_tile_row_number[1], req_tile_column[1]};
      group_in = (req_operation == OP_SPRITE) ? req_sprite_palette :
                 req_attribute_byte[{quad, 1'b0} +: 2];
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff && adv) begin
         cnt_in = cnt_ff + 3'd1;
         if (last_issue) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lo_ff     <= req_plane_low;
         hi_ff     <= req_plane_high;
         sprite_ff <= (req_operation == OP_SPRITE);
         flip_ff   <= req_flip_horizontal;
         group_ff  <= group_in;
      end
   end

   always_comb begin
      bidx = (sprite_ff && flip_ff) ? cnt_ff : LAST_COLUMN - cnt_ff;
      pix  = {hi_ff[bidx], lo_ff[bidx]};
      issue.valid  = busy_ff;
      issue.column = cnt_ff;
      if (sprite_ff) begin
         issue.addr   = {1'b1, group_ff, pix};
         issue.opaque = (pix != 2'd0);
      end else begin
         issue.addr   = (pix == 2'd0) ? '0 : {1'b0, group_ff, pix};
         issue.opaque = 1'b1;
      end
      status.busy       = busy_ff;
      status.last_issue = last_issue;
   end

endmodule

@@ hdl/trpc_pix_out.sv @@
// ----------------------------------------------------------------------------
// trpc_pix_out
// aligns pixel info with palette read data, maps to rgb, drives the rsp port
// ----------------------------------------------------------------------------
module trpc_pix_out
   import trpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  pix_req_type        issue,
   input  logic [COLOR_W-1:0] color,
   output logic               adv,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic               rsp_opaque,
   output logic [2:0]         rsp_pixel_column,
   output logic               rsp_last_pixel
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_opaque_ff;
   logic [2:0]  s1_col_ff;
   logic        out_valid_ff, out_valid_in;
   logic [23:0] rgb_ff, rgb_in;
   logic        opaque_ff;
   logic [2:0]  col_ff;
   logic        last_ff;

   assign adv = !out_valid_ff || !rsp_stall;

   always_comb begin
      s1_valid_in  = adv ? issue.valid : s1_valid_ff;
      out_valid_in = adv ? s1_valid_ff : out_valid_ff;
      rgb_in       = s1_opaque_ff ? sys_rgb(color) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_opaque_ff <= issue.opaque;
         s1_col_ff    <= issue.column;
         rgb_ff       <= rgb_in;
         opaque_ff    <= s1_opaque_ff;
         col_ff       <= s1_col_ff;
         last_ff      <= (s1_col_ff == LAST_COLUMN);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red          = rgb_ff[23:16];
   assign rsp_green        = rgb_ff[15:8];
   assign rsp_blue         = rgb_ff[7:0];
   assign rsp_opaque       = opaque_ff;
   assign rsp_pixel_column = col_ff;
   assign rsp_last_pixel   = last_ff;

endmodule

@@ hdl/tile_row_palette_colouriser_top.sv @@
// a row request's first pixel goes through the sequencer, palette read and rgb output registers to rsp
// throughput: one pixel per cycle while rsp_stall is low, set by the single palette
//   ram read port (one read per pixel); the next row is taken as the last pixel issues
// palette writes and unused operations give no pixel and start no row
// reset: synchronous; palette entries read as zero until written (flags clear at once)
// ----------------------------------------------------------------------------
// tile_row_palette_colouriser_top
// colors 8-pixel 2bpp background and sprite rows through a 32-entry palette
// ----------------------------------------------------------------------------
module tile_row_palette_colouriser_top
   import trpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_plane_low,
   input  logic [7:0] req_plane_high,
   input  logic [4:0] req_tile_column,
   input  logic [4:0] req_tile_row_number,
   input  logic [7:0] req_attribute_byte,
   input  logic [1:0] req_sprite_palette,
   input  logic       req_flip_horizontal,
   input  logic [4:0] req_palette_address,
   input  logic [5:0] req_palette_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_opaque,
   output logic [2:0] rsp_pixel_column,
   output logic       rsp_last_pixel
);

   pix_req_type        issue;
   seq_status_type     status;
   logic               adv;
   logic               wr_en;
   logic [COLOR_W-1:0] color;

   assign wr_en = req_valid && !req_stall && (req_operation == OP_WRITE);

   trpc_row_seq u_seq (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_plane_low       (req_plane_low),
      .req_plane_high      (req_plane_high),
      .req_tile_column     (req_tile_column),
      .req_tile_row_number (req_tile_row_number),
      .req_attribute_byte  (req_attribute_byte),
      .req_sprite_palette  (req_sprite_palette),
      .req_flip_horizontal (req_flip_horizontal),
      .adv                 (adv),
      .issue               (issue),
      .status              (status)
   );

   trpc_pal_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (req_palette_address),
      .wr_data (req_palette_value),
      .rd_en   (adv),
      .rd_addr (issue.addr),
      .color   (color)
   );

   trpc_pix_out u_out (
      .clock            (clock),
      .reset            (reset),
      .issue            (issue),
      .color            (color),
      .adv              (adv),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_opaque       (rsp_opaque),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_last_pixel   (rsp_last_pixel)
   );

`ifndef SYNTH
   a_row_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_operation == OP_BACKGROUND || req_operation == OP_SPRITE))
      |=> (status.busy && issue.column == 3'd0))
      else $error("row request did not start issuing at column 0");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (status.busy && !status.last_issue))
      else $error("request stalled while row engine free");

   a_transparent_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_opaque) |->
      (rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0))
      else $error("transparent pixel carries color");

   a_last_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_pixel == (rsp_pixel_column == LAST_COLUMN)))
      else $error("last pixel flag out of step with column");
`endif

endmodule
